// ----- sv/max_manhattan_distance_tracker_macros.svh -----
// assertion macros shared by the max manhattan distance tracker checker
`ifndef MAX_MANHATTAN_DISTANCE_TRACKER_MACROS_SVH
`define MAX_MANHATTAN_DISTANCE_TRACKER_MACROS_SVH

// clocked assertion, quiet while reset is high
`define MMDT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked assertion that also checks across reset
`define MMDT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- sv/mmdt_pkg.sv -----
// shared constants and types for the max manhattan distance tracker
`default_nettype none

package mmdt_pkg;

   // coordinates per point and sign patterns over coordinates 1 and up
   localparam int MAX_DIMS  = 4;
   localparam int NPAT      = 1 << (MAX_DIMS - 1);

   // dimension count register
   localparam int                   DIMS_BITS  = 3;
   localparam logic [DIMS_BITS-1:0] DIMS_RESET = 3'd2;

   // growth of a pattern sum and of the result over one coordinate
   localparam int PAT_GROW = 3;
   localparam int OUT_GROW = 2;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = $clog2(Q_DEPTH);

   // places a set's last word can sit: front reg, queue, final, diff, output
   localparam int PIPE_SLOTS = 4 + Q_DEPTH;

   // queue fill status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } mmdt_q_stat_type;

endpackage

`default_nettype wire

// ----- sv/max_manhattan_distance_tracker.sv -----
// Finds the greatest pairwise Manhattan distance in a set of points, one point per word.
// Each point carries four signed coordinates, of which the first csr_wr_data-configured
// count take part (0 acts as 1, above 4 as 4; reset value 2); the count is sampled as each
// point is taken. For each of eight sign patterns the front forms coordinate 0 plus or
// minus the others, and the back keeps a running max and min per pattern. A point flagged
// req_last_point closes the set: the largest max-minus-min appears on rsp_max_distance
// and the trackers start over. Points are taken one per cycle, sustained, as long as
// results are drained; a result passes through the front sum register, the two-word queue
// and the three-stage result pipe (final extremes, per-pattern spread, compare and clip).
`default_nettype none

module max_manhattan_distance_tracker
   import mmdt_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [DIMS_BITS-1:0]              csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [COORD_BITS-1:0]      req_coord_0,
   input  logic signed [COORD_BITS-1:0]      req_coord_1,
   input  logic signed [COORD_BITS-1:0]      req_coord_2,
   input  logic signed [COORD_BITS-1:0]      req_coord_3,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [COORD_BITS+OUT_GROW-1:0]    rsp_max_distance
);

   localparam int WORD_BITS = NPAT * (COORD_BITS + PAT_GROW) + 1;

   logic signed [COORD_BITS-1:0] coord [MAX_DIMS];
   mmdt_q_stat_type              q_stat;
   logic                         q_push;
   logic                         q_pop;
   logic [WORD_BITS-1:0]         push_word;
   logic [WORD_BITS-1:0]         head_word;

   // coordinate ports gathered in order
   assign coord[0] = req_coord_0;
   assign coord[1] = req_coord_1;
   assign coord[2] = req_coord_2;
   assign coord[3] = req_coord_3;

   mmdt_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_coord      (coord),
      .req_last_point (req_last_point),
      .q_stat         (q_stat),
      .q_push         (q_push),
      .q_word         (push_word)
   );

   mmdt_queue #(
      .WIDTH (WORD_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (push_word),
      .pop       (q_pop),
      .head_word (head_word),
      .stat      (q_stat)
   );

   mmdt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_stat           (q_stat),
      .q_word           (head_word),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_distance (rsp_max_distance)
   );

endmodule

`default_nettype wire

// ----- sv/mmdt_front.sv -----
// front: takes points, masks unused coordinates and forms the pattern sums
`default_nettype none

module mmdt_front
   import mmdt_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [DIMS_BITS-1:0]         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_coord [MAX_DIMS],
   input  logic                         req_last_point,
   input  mmdt_q_stat_type              q_stat,
   output logic                         q_push,
   output logic [NPAT*(COORD_BITS+PAT_GROW):0] q_word
);

   localparam int PAT_BITS  = COORD_BITS + PAT_GROW;
   localparam int WORD_BITS = NPAT * PAT_BITS + 1;

   logic [DIMS_BITS-1:0]       dims_ff;
   logic                       vld_ff;
   logic                       vld_in;
   logic                       last_ff;
   logic signed [PAT_BITS-1:0] sum_ff [NPAT];
   logic signed [PAT_BITS-1:0] sum_in [NPAT];
   logic signed [PAT_BITS-1:0] term [MAX_DIMS];
   logic                       accept;

   // dimension count register
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIMS_RESET;
      end else if (csr_wr_en) begin
         dims_ff <= csr_wr_data;
      end
   end

   // coordinate 0 always counts, coordinate j only while the count exceeds j
   always_comb begin
      for (int j = 0; j < MAX_DIMS; j++) begin
         if (j == 0 || dims_ff > DIMS_BITS'(j)) begin
            term[j] = {{PAT_GROW{req_coord[j][COORD_BITS-1]}}, req_coord[j]};
         end else begin
            term[j] = '0;
         end
      end
   end

   // signed sum per pattern, bit j-1 of the pattern subtracts coordinate j
   always_comb begin
      for (int p = 0; p < NPAT; p++) begin
         sum_in[p] = term[0];
         for (int j = 1; j < MAX_DIMS; j++) begin
            if (((p >> (j - 1)) & 1) != 0) begin
               sum_in[p] = sum_in[p] - term[j];
            end else begin
               sum_in[p] = sum_in[p] + term[j];
            end
         end
      end
   end

   // handshake: the held word moves on whenever the queue has room
   assign q_push    = vld_ff && !q_stat.full;
   assign req_stall = vld_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (q_push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // word payload
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_last_point;
         for (int p = 0; p < NPAT; p++) begin
            sum_ff[p] <= sum_in[p];
         end
      end
   end

   // pack sums and last flag for the queue
   always_comb begin
      q_word[WORD_BITS-1] = last_ff;
      for (int p = 0; p < NPAT; p++) begin
         q_word[p*PAT_BITS +: PAT_BITS] = sum_ff[p];
      end
   end

endmodule

`default_nettype wire

// ----- sv/mmdt_queue.sv -----
// small register queue between the front and the back
`default_nettype none

module mmdt_queue
   import mmdt_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_word,
   input  logic             pop,
   output logic [WIDTH-1:0] head_word,
   output mmdt_q_stat_type  stat
);

   logic [WIDTH-1:0] mem_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff;
   logic [Q_AW-1:0]  wr_ptr_in;
   logic [Q_AW-1:0]  rd_ptr_ff;
   logic [Q_AW-1:0]  rd_ptr_in;
   logic [Q_AW:0]    cnt_ff;
   logic [Q_AW:0]    cnt_in;

   // pointers wrap on their own, the depth is a power of two
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + {{Q_AW{1'b0}}, push} - {{Q_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign head_word  = mem_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == (Q_AW + 1)'(Q_DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

`default_nettype wire

// ----- sv/mmdt_back.sv -----
// back: per-pattern max and min trackers and the result pipeline
`default_nettype none

module mmdt_back
   import mmdt_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mmdt_q_stat_type                     q_stat,
   input  logic [NPAT*(COORD_BITS+PAT_GROW):0] q_word,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [COORD_BITS+OUT_GROW-1:0]      rsp_max_distance
);

   localparam int PAT_BITS  = COORD_BITS + PAT_GROW;
   localparam int OUT_BITS  = COORD_BITS + OUT_GROW;
   localparam int DIFF_BITS = PAT_BITS + 1;
   localparam int WORD_BITS = NPAT * PAT_BITS + 1;

   localparam logic signed [PAT_BITS-1:0] MOST_NEG = {1'b1, {(PAT_BITS - 1){1'b0}}};
   localparam logic signed [PAT_BITS-1:0] MOST_POS = {1'b0, {(PAT_BITS - 1){1'b1}}};
   localparam logic signed [DIFF_BITS-1:0] CAP =
      {{(DIFF_BITS - OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}};

   logic signed [PAT_BITS-1:0]  head_sum [NPAT];
   logic                        head_last;
   logic signed [PAT_BITS-1:0]  max_ff [NPAT];
   logic signed [PAT_BITS-1:0]  min_ff [NPAT];
   logic signed [PAT_BITS-1:0]  max_upd [NPAT];
   logic signed [PAT_BITS-1:0]  min_upd [NPAT];
   logic signed [PAT_BITS-1:0]  fmax_ff [NPAT];
   logic signed [PAT_BITS-1:0]  fmin_ff [NPAT];
   logic                        f_vld_ff;
   logic                        f_vld_in;
   logic signed [DIFF_BITS-1:0] diff_ff [NPAT];
   logic signed [DIFF_BITS-1:0] diff_in [NPAT];
   logic                        d_vld_ff;
   logic                        d_vld_in;
   logic [OUT_BITS-1:0]         dist_ff;
   logic [OUT_BITS-1:0]         dist_in;
   logic                        rsp_vld_ff;
   logic                        rsp_vld_in;
   logic signed [DIFF_BITS-1:0] best;
   logic                        o_load;
   logic                        d_load;
   logic                        d_free;
   logic                        f_free;
   logic                        pop_last;

   // unpack the head word
   always_comb begin
      head_last = q_word[WORD_BITS-1];
      for (int p = 0; p < NPAT; p++) begin
         head_sum[p] = q_word[p*PAT_BITS +: PAT_BITS];
      end
   end

   // result pipeline flow, a later stage frees an earlier one
   assign o_load   = d_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign d_free   = !d_vld_ff || o_load;
   assign d_load   = f_vld_ff && d_free;
   assign f_free   = !f_vld_ff || d_load;
   assign q_pop    = !q_stat.empty && (!head_last || f_free);
   assign pop_last = q_pop && head_last;

   // tracker compare against the popped sums
   always_comb begin
      for (int p = 0; p < NPAT; p++) begin
         max_upd[p] = (head_sum[p] > max_ff[p]) ? head_sum[p] : max_ff[p];
         min_upd[p] = (head_sum[p] < min_ff[p]) ? head_sum[p] : min_ff[p];
      end
   end

   // trackers return to their extremes once a set closes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NPAT; p++) begin
            max_ff[p] <= MOST_NEG;
            min_ff[p] <= MOST_POS;
         end
      end else if (q_pop) begin
         for (int p = 0; p < NPAT; p++) begin
            max_ff[p] <= head_last ? MOST_NEG : max_upd[p];
            min_ff[p] <= head_last ? MOST_POS : min_upd[p];
         end
      end
   end

   // final extremes of the closed set
   always_ff @(posedge clock) begin
      if (pop_last) begin
         for (int p = 0; p < NPAT; p++) begin
            fmax_ff[p] <= max_upd[p];
            fmin_ff[p] <= min_upd[p];
         end
      end
   end

   // spread per pattern
   always_comb begin
      for (int p = 0; p < NPAT; p++) begin
         diff_in[p] = {fmax_ff[p][PAT_BITS-1], fmax_ff[p]}
                    - {fmin_ff[p][PAT_BITS-1], fmin_ff[p]};
      end
   end

   always_ff @(posedge clock) begin
      if (d_load) begin
         for (int p = 0; p < NPAT; p++) begin
            diff_ff[p] <= diff_in[p];
         end
      end
   end

   // largest spread, floored at zero and clipped to the output width
   always_comb begin
      best = '0;
      for (int p = 0; p < NPAT; p++) begin
         if (diff_ff[p] > best) begin
            best = diff_ff[p];
         end
      end
      if (best > CAP) begin
         dist_in = '1;
      end else begin
         dist_in = best[OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         dist_ff <= dist_in;
      end
   end

   // stage valids
   always_comb begin
      if (pop_last) begin
         f_vld_in = 1'b1;
      end else if (d_load) begin
         f_vld_in = 1'b0;
      end else begin
         f_vld_in = f_vld_ff;
      end

      if (d_load) begin
         d_vld_in = 1'b1;
      end else if (o_load) begin
         d_vld_in = 1'b0;
      end else begin
         d_vld_in = d_vld_ff;
      end

      if (o_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         f_vld_ff   <= f_vld_in;
         d_vld_ff   <= d_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_max_distance = dist_ff;

endmodule

`default_nettype wire

// ----- sv/mmdt_checker.sv -----
// port-level checker for the max manhattan distance tracker, with its bind
`default_nettype none
`include "max_manhattan_distance_tracker_macros.svh"

module mmdt_checker
   import mmdt_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_last_point,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [COORD_BITS+OUT_GROW-1:0] rsp_max_distance
);

   localparam int CNT_BITS = $clog2(PIPE_SLOTS + 2);

   logic [CNT_BITS-1:0] open_ff;
   logic [CNT_BITS-1:0] open_in;

   // closed sets taken whose result has not yet gone out
   always_comb begin
      open_in = open_ff
              + {{(CNT_BITS - 1){1'b0}}, req_valid && !req_stall && req_last_point}
              - {{(CNT_BITS - 1){1'b0}}, rsp_valid && !rsp_stall};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `MMDT_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_max_distance), "result changed while stalled")
   `MMDT_ASSERT(a_rsp_has_set, rsp_valid |-> open_ff != '0, "result with no closed set pending")
   `MMDT_ASSERT(a_open_bound, open_ff <= CNT_BITS'(PIPE_SLOTS), "more closed sets pending than the pipe holds")
   `MMDT_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid && !req_stall, "not quiet after reset")

endmodule

bind max_manhattan_distance_tracker mmdt_checker #(
   .COORD_BITS (COORD_BITS)
) u_mmdt_checker (.*);

`default_nettype wire

// ----- tb/max_manhattan_distance_tracker_tb.sv -----
// testbench for the max manhattan distance tracker: directed and random point sets, scoreboard check
module max_manhattan_distance_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mmdt_pkg::*;

   localparam int COORD_BITS    = 16;
   localparam int PAT_BITS      = COORD_BITS + PAT_GROW;
   localparam int OUT_BITS      = COORD_BITS + OUT_GROW;
   localparam int DRAIN_CYCLES  = 4 * PIPE_SLOTS;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SEGMENTS      = 8;
   localparam int SEGMENT_WORDS = 124;
   localparam logic [DIMS_BITS-1:0] DIMS_PLAN [SEGMENTS] = '{
      3'd4, 3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd2, 3'd6
   };

   typedef logic signed [COORD_BITS-1:0] coord_type;

   // one point as it travels on the request channel
   typedef struct packed {
      logic [MAX_DIMS-1:0][COORD_BITS-1:0] coord;
      logic                                last;
   } point_type;

   // tracks per-pattern extremes and holds the distances still to come
   class l1_spread_board_type;
      logic [DIMS_BITS-1:0]       dims;
      logic signed [PAT_BITS-1:0] run_hi [NPAT];
      logic signed [PAT_BITS-1:0] run_lo [NPAT];
      logic [OUT_BITS-1:0]        awaited_distance [$];
      int                         errors;

      function new();
         dims   = DIMS_RESET;
         errors = 0;
         clear_runs();
      endfunction

      function void clear_runs();
         for (int p = 0; p < NPAT; p++) begin
            run_hi[p] = {1'b1, {(PAT_BITS-1){1'b0}}};
            run_lo[p] = {1'b0, {(PAT_BITS-1){1'b1}}};
         end
      endfunction

      // fold one accepted point into the trackers, close the set on its last point
      function void take_point(point_type pt);
         int used;
         int c [MAX_DIMS];
         int s;
         int best;
         used = (dims == 0) ? 1 : (dims > MAX_DIMS) ? MAX_DIMS : int'(dims);
         for (int j = 0; j < MAX_DIMS; j++) begin
            c[j] = (j < used) ? int'(coord_type'(pt.coord[j])) : 0;
         end
         for (int p = 0; p < NPAT; p++) begin
            s = c[0];
            for (int j = 1; j < MAX_DIMS; j++) begin
               if (((p >> (j - 1)) & 1) != 0) begin
                  s -= c[j];
               end else begin
                  s += c[j];
               end
            end
            if (s > run_hi[p]) run_hi[p] = PAT_BITS'(s);
            if (s < run_lo[p]) run_lo[p] = PAT_BITS'(s);
         end
         if (!pt.last) return;
         best = 0;
         for (int p = 0; p < NPAT; p++) begin
            if (int'(run_hi[p]) - int'(run_lo[p]) > best) begin
               best = int'(run_hi[p]) - int'(run_lo[p]);
            end
         end
         // clip to the output width
         if (best > (1 << OUT_BITS) - 1) best = (1 << OUT_BITS) - 1;
         awaited_distance = {awaited_distance, OUT_BITS'(best)};
         clear_runs();
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_distance(logic [OUT_BITS-1:0] got);
         logic [OUT_BITS-1:0] want;
         if (awaited_distance.size() == 0) begin
            report($sformatf("distance %0d with none awaited", got));
            return;
         end
         want = awaited_distance.pop_front();
         if (got !== want) begin
            report($sformatf("max_distance got %0d want %0d", got, want));
         end
      endtask
   endclass

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 csr_wr_en   = 1'b0;
   logic [DIMS_BITS-1:0] csr_wr_data = '0;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   point_type            req_word    = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic [OUT_BITS-1:0]  rsp_max_distance;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles  = 0;

   l1_spread_board_type board = new();

   max_manhattan_distance_tracker #(
      .COORD_BITS(COORD_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_coord_0      (req_word.coord[0]),
      .req_coord_1      (req_word.coord[1]),
      .req_coord_2      (req_word.coord[2]),
      .req_coord_3      (req_word.coord[3]),
      .req_last_point   (req_word.last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_distance (rsp_max_distance)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // result check and watchdog on handshake progress
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_distance(rsp_max_distance);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic point_type point_at(int c0, int c1, int c2, int c3, logic last);
      point_type pt;
      pt.coord[0] = COORD_BITS'(c0);
      pt.coord[1] = COORD_BITS'(c1);
      pt.coord[2] = COORD_BITS'(c2);
      pt.coord[3] = COORD_BITS'(c3);
      pt.last     = last;
      return pt;
   endfunction

   // random point, leaning on extremes and values near zero
   function automatic point_type random_point(logic last);
      point_type pt;
      for (int j = 0; j < MAX_DIMS; j++) begin
         case ($urandom_range(9))
            0: begin
               pt.coord[j] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end
            1: begin
               pt.coord[j] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
            2: begin
               pt.coord[j] = COORD_BITS'($urandom_range(8)) - COORD_BITS'(4);
            end
            default: begin
               pt.coord[j] = COORD_BITS'($urandom);
            end
         endcase
      end
      pt.last = last;
      return pt;
   endfunction

   // present one word, with random idle cycles ahead of it, and hold until taken
   task automatic send_point(point_type pt);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= pt;
      do @(posedge clock); while (req_stall);
      board.take_point(pt);
   endtask

   // stop sending, wait for every awaited distance, then let the pipe empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited_distance.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(logic [DIMS_BITS-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.dims = value;
   endtask

   initial begin
      int words;
      int set_len;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset dimension count: opposite corners, unused coordinates set
      send_point(point_at(32767, 32767, 0, 0, 1'b0));
      send_point(point_at(-32768, -32768, 5, 5, 1'b1));
      settle();

      // all four dimensions: largest possible distance, then mixed signs
      write_dims(3'd4);
      send_point(point_at(32767, 32767, 32767, 32767, 1'b0));
      send_point(point_at(-32768, -32768, -32768, -32768, 1'b1));
      send_point(point_at(32767, -32768, 32767, -32768, 1'b0));
      send_point(point_at(-32768, 32767, -32768, 32767, 1'b0));
      send_point(point_at(0, 0, 0, 0, 1'b1));
      // single point set
      send_point(random_point(1'b1));
      settle();

      // one dimension, large values in the ignored coordinates
      write_dims(3'd1);
      send_point(point_at(100, 32767, -32768, 5, 1'b0));
      send_point(point_at(-50, -32768, 32767, 9, 1'b1));
      settle();

      // zero count acts as one
      write_dims(3'd0);
      send_point(point_at(0, 1, 2, 3, 1'b0));
      send_point(point_at(-32768, 32767, 32767, 32767, 1'b1));
      settle();

      // count above the maximum acts as the maximum
      write_dims(3'd7);
      send_point(point_at(-1, -1, -1, -1, 1'b0));
      send_point(point_at(1, 1, -1, 1, 1'b1));
      settle();

      // dimension count changed in the middle of a set
      write_dims(3'd3);
      send_point(point_at(1000, -2000, 3000, -32768, 1'b0));
      send_point(point_at(-1000, 2000, -3000, 32767, 1'b0));
      settle();
      write_dims(3'd1);
      send_point(point_at(5, 32767, 32767, 32767, 1'b1));
      settle();

      // random sets, one dimension count per segment, three idling phases
      for (int g = 0; g < SEGMENTS; g++) begin
         if (g == 0) begin
            send_idle_pct = 20;
            recv_idle_pct = 74;
         end else if (g == 3) begin
            send_idle_pct = 74;
            recv_idle_pct = 20;
         end else if (g == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_dims(DIMS_PLAN[g]);
         words = 0;
         while (words < SEGMENT_WORDS) begin
            // mostly short sets, now and then a long one
            set_len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            for (int i = 1; i <= set_len; i++) begin
               send_point(random_point(i == set_len));
            end
            words += set_len;
         end
         settle();
      end

      if (board.errors == 0 && board.awaited_distance.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mmdt_pkg.sv
sv/mmdt_front.sv
sv/mmdt_queue.sv
sv/mmdt_back.sv
sv/max_manhattan_distance_tracker.sv
sv/mmdt_checker.sv
tb/max_manhattan_distance_tracker_tb.sv
